// ===== design/ip_range_rule_classifier_core_defines.svh =====
// Assertion macros used by the rule classifier top level.
`ifndef IP_RANGE_RULE_CLASSIFIER_CORE_DEFINES_SVH
`define IP_RANGE_RULE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IPRC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IPRC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/iprc_pkg.sv =====
// Types and codes shared by the rule classifier cells and top level.
package iprc_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_ADDR   = 2'd1,
    FUNC_FINISH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    DEC_DIRECT    = 2'd0,
    DEC_PROXY     = 2'd1,
    DEC_UNDECIDED = 2'd2
  } decision_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic        valid;
    logic        list;
    logic        prio;
    logic        kind;
    logic [31:0] low;
    logic [31:0] high;
  } rule_t;

  typedef struct packed {
    logic use_first;
    logic direct;
    logic use_later;
  } hits_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] addr;
    hits_t       hits;
  } tok_t;

endpackage

// ===== design/iprc_cell.sv =====
// One rule slot of the chain: stores a rule and matches the passing address.
module iprc_cell import iprc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  rule_t wr_rule_i,
  input  tok_t  tok_i,
  output tok_t  tok_o
);

  logic        valid_q, list_q, prio_q, kind_q;
  logic [31:0] low_q, high_q;
  tok_t        tok_d, tok_q;
  logic        hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      list_q  <= 1'b0;
      prio_q  <= 1'b0;
      kind_q  <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= wr_rule_i.valid;
      list_q  <= wr_rule_i.list;
      prio_q  <= wr_rule_i.prio;
      kind_q  <= wr_rule_i.kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      low_q  <= wr_rule_i.low;
      high_q <= wr_rule_i.high;
    end
  end

  always_comb begin
    if (kind_q) begin
      hit = valid_q && (low_q <= tok_i.addr) && (tok_i.addr <= high_q);
    end else begin
      hit = valid_q && ((tok_i.addr & high_q) == low_q);
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && hit) begin
      if (!list_q) begin
        if (prio_q) begin
          tok_d.hits.use_first = 1'b1;
        end else begin
          tok_d.hits.use_later = 1'b1;
        end
      end else if (!prio_q) begin
        tok_d.hits.direct = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== design/ip_range_rule_classifier_core.sv =====
// Top level of the IPv4 subnet and span rule classifier.
//
//   Channel  Signals                         Moves
//   in       in_valid_i / in_ready_o         one item: rule write, address or finish
//   out      out_valid_o / out_ready_i       one decision per finish item
//
// A rule write writes one cell of the chain.
// A nonzero address travels the chain of RULE_SLOTS cells, one cell per cycle;
// an address of zero does not enter the chain.
// Any item waits while an undelivered decision holds the output register.
// Reset clears all slots to invalid and the hit flags to zero; no clearing pass is needed.
`include "ip_range_rule_classifier_core_defines.svh"

module ip_range_rule_classifier_core import iprc_pkg::*; #(
  parameter int RULE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  rule_index_i,
  input  logic        rule_valid_i,
  input  logic        rule_list_i,
  input  logic        rule_priority_i,
  input  logic        rule_kind_i,
  input  logic [31:0] word_a_i,
  input  logic [31:0] word_b_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  decision_o
);

  state_e                state_q, state_d;
  hits_t                 hit_q, hit_d;
  logic                  out_valid_q, out_valid_d;
  decision_e             decision_q, decision_d;
  logic                  accept;
  logic                  scan_accept, finish_accept;
  logic                  do_write, do_scan, do_finish;
  rule_t                 wr_rule;
  tok_t                  tok_in;
  tok_t                  chain [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] chain_vld;
  logic [RULE_SLOTS-1:0] wr_en;
  tok_t                  tok_last;

  assign accept        = in_valid_i && in_ready_o;
  assign scan_accept   = accept && (func_i == FUNC_ADDR) && (address_i != 32'd0);
  assign finish_accept = accept && (func_i == FUNC_FINISH);
  assign tok_last      = chain[RULE_SLOTS-1];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_last.vld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    do_write   = 1'b0;
    do_scan    = 1'b0;
    do_finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          case (func_i)
            FUNC_WRITE:  do_write  = 1'b1;
            FUNC_ADDR:   do_scan   = (address_i != 32'd0);
            FUNC_FINISH: do_finish = 1'b1;
            default:     do_write  = 1'b0;
          endcase
        end
      end
      ST_SCAN: in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    wr_rule.valid = rule_valid_i && !(rule_kind_i && (word_a_i > word_b_i));
    wr_rule.list  = rule_list_i;
    wr_rule.prio  = rule_priority_i;
    wr_rule.kind  = rule_kind_i;
    wr_rule.low   = rule_kind_i ? word_a_i : (word_a_i & word_b_i);
    wr_rule.high  = word_b_i;
  end

  always_comb begin
    tok_in.vld  = do_scan;
    tok_in.addr = address_i;
    tok_in.hits = '0;
  end

  for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_cell
    tok_t tok_prev;

    if (k == 0) begin : g_head
      assign tok_prev = tok_in;
    end else begin : g_link
      assign tok_prev = chain[k-1];
    end

    assign wr_en[k]     = do_write && (32'(rule_index_i) == 32'(k));
    assign chain_vld[k] = chain[k].vld;

    iprc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en[k]),
      .wr_rule_i (wr_rule),
      .tok_i     (tok_prev),
      .tok_o     (chain[k])
    );
  end

  always_comb begin
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    decision_d  = decision_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_SCAN && tok_last.vld) begin
      hit_d = hit_q | tok_last.hits;
    end
    if (do_finish) begin
      if (hit_q.use_first) begin
        decision_d = DEC_PROXY;
      end else if (hit_q.direct) begin
        decision_d = DEC_DIRECT;
      end else if (hit_q.use_later) begin
        decision_d = DEC_PROXY;
      end else begin
        decision_d = DEC_UNDECIDED;
      end
      out_valid_d = 1'b1;
      hit_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    decision_q <= decision_d;
  end

  assign out_valid_o = out_valid_q;
  assign decision_o  = decision_q;

  `IPRC_ASSERT_NOW(a_idle_chain_empty, state_q == ST_IDLE, chain_vld == '0, "Item while idle.")
  `IPRC_ASSERT_NOW(a_one_item_in_chain, state_q == ST_SCAN, $onehot0(chain_vld), "Two items.")
  `IPRC_ASSERT_NEXT(a_scan_starts, scan_accept, state_q == ST_SCAN, "Scan did not start.")
  `IPRC_ASSERT_NEXT(a_finish_clears, finish_accept, out_valid_o && hit_q == '0, "No finish result.")

endmodule

// ===== dv/ip_range_rule_classifier_checker.sv =====
// Checker that predicts and compares the decisions of the rule classifier.
module ip_range_rule_classifier_checker import iprc_pkg::*; #(
  parameter int RULE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [3:0]  rule_index_i,
  input  logic        rule_valid_i,
  input  logic        rule_list_i,
  input  logic        rule_priority_i,
  input  logic        rule_kind_i,
  input  logic [31:0] word_a_i,
  input  logic [31:0] word_b_i,
  input  logic [31:0] address_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  decision_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        on;
    logic        no_proxy;
    logic        urgent;
    logic        span;
    logic [31:0] lo;
    logic [31:0] hi;
  } slot_t;

  slot_t     slots [RULE_SLOTS];
  logic      use_first_hit;
  logic      direct_hit;
  logic      use_later_hit;
  decision_e expected_decisions [$];

  function automatic logic slot_matches(slot_t s, logic [31:0] a);
    if (!s.on) return 1'b0;
    if (s.span) return (s.lo <= a) && (a <= s.hi);
    return (a & s.hi) == s.lo;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_e want;
    if (!rst_ni) begin
      foreach (slots[s]) slots[s] = '0;
      use_first_hit = 1'b0;
      direct_hit = 1'b0;
      use_later_hit = 1'b0;
      expected_decisions.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (func_e'(func_i))
          FUNC_WRITE: begin
            if (rule_index_i < RULE_SLOTS) begin
              slots[rule_index_i].on = rule_valid_i && !(rule_kind_i && word_a_i > word_b_i);
              slots[rule_index_i].no_proxy = rule_list_i;
              slots[rule_index_i].urgent = rule_priority_i;
              slots[rule_index_i].span = rule_kind_i;
              slots[rule_index_i].lo = rule_kind_i ? word_a_i : (word_a_i & word_b_i);
              slots[rule_index_i].hi = word_b_i;
            end
          end
          FUNC_ADDR: begin
            if (address_i != '0) begin
              foreach (slots[s]) begin
                if (slot_matches(slots[s], address_i)) begin
                  if (!slots[s].no_proxy) begin
                    if (slots[s].urgent) use_first_hit = 1'b1;
                    else use_later_hit = 1'b1;
                  end else if (!slots[s].urgent) begin
                    direct_hit = 1'b1;
                  end
                end
              end
            end
          end
          FUNC_FINISH: begin
            if (use_first_hit) want = DEC_PROXY;
            else if (direct_hit) want = DEC_DIRECT;
            else if (use_later_hit) want = DEC_PROXY;
            else want = DEC_UNDECIDED;
            expected_decisions.push_back(want);
            use_first_hit = 1'b0;
            direct_hit = 1'b0;
            use_later_hit = 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_decisions.size() == 0) begin
          fail_count_o++;
          $display("%0t: decision %0d arrived with none expected", $time, decision_i);
        end else begin
          want = expected_decisions.pop_front();
          if (decision_i !== want) begin
            fail_count_o++;
            $display("%0t: decision mismatch, expected %0d (%s), got %0d",
                     $time, want, want.name(), decision_i);
          end
        end
      end
      pending_o = expected_decisions.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the rule classifier testbench: clock, reset, stimulus and verdict.
module testbench;
  import iprc_pkg::*;

  localparam int RULE_SLOTS = 16;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_NONE;
  logic [3:0]  rule_index_i = '0;
  logic        rule_valid_i = 1'b0;
  logic        rule_list_i = 1'b0;
  logic        rule_priority_i = 1'b0;
  logic        rule_kind_i = 1'b0;
  logic [31:0] word_a_i = '0;
  logic [31:0] word_b_i = '0;
  logic [31:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  decision_o;

  int fail_count;
  int pending_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  logic [31:0] shadow_lo [RULE_SLOTS];
  logic [31:0] shadow_hi [RULE_SLOTS];
  logic        shadow_span [RULE_SLOTS];

  ip_range_rule_classifier_core #(.RULE_SLOTS(RULE_SLOTS)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .rule_index_i, .rule_valid_i,
    .rule_list_i, .rule_priority_i, .rule_kind_i, .word_a_i, .word_b_i, .address_i,
    .out_valid_o, .out_ready_i, .decision_o
  );

  ip_range_rule_classifier_checker #(.RULE_SLOTS(RULE_SLOTS)) decision_check (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .rule_index_i,
    .rule_valid_i, .rule_list_i, .rule_priority_i, .rule_kind_i, .word_a_i, .word_b_i,
    .address_i, .out_valid_i(out_valid_o), .out_ready_i, .decision_i(decision_o),
    .fail_count_o(fail_count), .pending_o(pending_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] f, input logic [3:0] idx,
                           input logic v, input logic l, input logic p, input logic k,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    rule_index_i <= idx;
    rule_valid_i <= v;
    rule_list_i <= l;
    rule_priority_i <= p;
    rule_kind_i <= k;
    word_a_i <= a;
    word_b_i <= b;
    address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (f != FUNC_NONE) items_sent++;
  endtask

  task automatic write_rule(input logic [3:0] idx, input logic v, input logic l,
                            input logic p, input logic k,
                            input logic [31:0] a, input logic [31:0] b);
    shadow_lo[idx] = a;
    shadow_hi[idx] = b;
    shadow_span[idx] = k;
    send_item(FUNC_WRITE, idx, v, l, p, k, a, b, $urandom);
  endtask

  task automatic present(input logic [31:0] addr);
    send_item(FUNC_ADDR, 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), $urandom, $urandom, addr);
  endtask

  task automatic finish_item();
    send_item(FUNC_FINISH, 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic noise_item();
    send_item(FUNC_NONE, 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_address();
    int s;
    logic [31:0] lo;
    logic [31:0] hi;
    s = $urandom_range(RULE_SLOTS - 1);
    lo = shadow_lo[s];
    hi = shadow_hi[s];
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return '1;
      default: begin
        if (!shadow_span[s]) return (lo & hi) | ($urandom & ~hi);
        if (lo > hi) return $urandom;
        case ($urandom_range(2))
          0: return lo;
          1: return hi;
          default: return $urandom_range(hi, lo);
        endcase
      end
    endcase
  endfunction

  task automatic random_rule();
    logic [31:0] a;
    logic [31:0] b;
    logic        k;
    k = 1'($urandom_range(1));
    a = $urandom;
    if (!k) begin
      case ($urandom_range(7))
        0: b = $urandom;
        1: b = '1;
        2: b = '0;
        default: b = 32'hFFFF_FFFF << $urandom_range(32);
      endcase
    end else begin
      case ($urandom_range(7))
        0: b = $urandom;
        1: b = a;
        2: begin
          a = '0;
          b = '1;
        end
        default: b = a + $urandom_range(65535);
      endcase
    end
    write_rule(4'($urandom_range(RULE_SLOTS - 1)), $urandom_range(9) != 0,
               1'($urandom_range(1)), $urandom_range(3) == 0, k, a, b);
  endtask

  task automatic run_phase(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      repeat ($urandom_range(3)) random_rule();
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(19) == 0) noise_item();
        else present(pick_address());
      end
      if ($urandom_range(9) != 0) finish_item();
    end
  endtask

  initial begin
    foreach (shadow_lo[s]) begin
      shadow_lo[s] = '0;
      shadow_hi[s] = '0;
      shadow_span[s] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_rule(4'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0A01_0203, 32'hFF00_0000);
    write_rule(4'd1, 1'b1, 1'b1, 1'b0, 1'b1, 32'hC0A8_0000, 32'hC0A8_FFFF);
    write_rule(4'd2, 1'b1, 1'b0, 1'b1, 1'b1, 32'h0B00_0010, 32'h0B00_0001);
    write_rule(4'd3, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_rule(4'd4, 1'b1, 1'b0, 1'b1, 1'b0, 32'hA5B5_C5D5, 32'hF0F0_F0F0);
    write_rule(4'd15, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    finish_item();
    present(32'h0A0A_0A0A);
    finish_item();
    present(32'hC0A8_0101);
    present(32'h0A00_0001);
    finish_item();
    present(32'h0000_0000);
    present(32'hFFFF_FFFF);
    finish_item();
    present(32'hAFBF_CFDF);
    present(32'hC0A8_0001);
    finish_item();
    present(32'h0B00_0005);
    noise_item();
    finish_item();
    write_rule(4'd15, 1'b1, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    present(32'h0000_0001);
    finish_item();
    drain();

    run_phase(200);
    drain();
    idle_pct = 83;
    run_phase(200);
    drain();
    idle_pct = 0;
    stall_pct = 83;
    run_phase(200);
    drain();
    idle_pct = 16;
    stall_pct = 16;
    run_phase(200);
    drain();

    repeat (RULE_SLOTS + 8) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/iprc_pkg.sv
design/iprc_cell.sv
design/ip_range_rule_classifier_core.sv
dv/ip_range_rule_classifier_checker.sv
dv/testbench.sv
